>>> design/tlbpt_pkg.sv
// Shared types and constants for the TLB / page table translator.
// Used by tlbpt_tlb and the top level; no dependencies.
`default_nettype none

package tlbpt_pkg;

   // Address split
   localparam int VA_W        = 16;
   localparam int PAGE_BITS   = 8;
   localparam int OFFSET_BITS = 8;
   localparam int PAGE_COUNT  = 1 << PAGE_BITS;

   // TLB geometry
   localparam int TLB_ENTRIES = 16;
   localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);

   // Physical frames
   localparam int FRAME_COUNT = 256;
   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int FREE_W      = FRAME_W + 1;
   localparam int PA_W        = 16;
   localparam int FIDX_W      = 8;

   // Stream payload widths
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 3;

   // Write into one TLB entry
   typedef struct packed {
      logic                 en;
      logic [TLB_IDX_W-1:0] idx;
      logic [PAGE_BITS-1:0] page;
      logic [FRAME_W-1:0]   frame;
   } tlbpt_tlb_wr_type;

   // Result of comparing one TLB entry
   typedef struct packed {
      logic               match;
      logic [FRAME_W-1:0] frame;
   } tlbpt_tlb_cmp_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_PTREAD = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_HOLD   = 5'b10000
   } tlbpt_state_type;

endpackage

`default_nettype wire

>>> design/tlb_page_table_translator_unit.sv
// Top level: sequencer, page table valid bits, free frame counter, output item register.
// Depends on tlbpt_pkg, tlbpt_tlb and tlbpt_ram.
`default_nettype none

// Translates a 16-bit logical address (page in bits 15..8, offset in 7..0)
// to a physical address. A small sequencer walks the 16 TLB entries through
// one comparator, one entry per cycle, lowest entry first. A hit ends the
// walk at the matching entry, and its result is then loaded into the output
// register; a TLB miss compares all 16 entries, reads the page table from
// the synchronous frame RAM and then loads the result. On a miss an
// unmapped page is given the next free frame and the TLB entry at the FIFO
// pointer is refilled. When no frames remain, the item returns with
// out_of_frames set and nothing is mapped. req_tready is high only while the
// sequencer is idle; a finished item waits in the output register, so the
// next request may be accepted while the previous result is still pending.
// The page table valid bits clear at reset; there is no clearing pass.
module tlb_page_table_translator_unit
   import tlbpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] virtual_address
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [15:0] physical_address, [23:16] frame_index
   output logic [RSP_USER_W-1:0]      rsp_tuser   // [0] tlb_hit, [1] page_fault, [2] out_of_frames
);

   tlbpt_state_type        state_ff, state_in;
   logic [TLB_IDX_W-1:0]   idx_ff, idx_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [TLB_IDX_W-1:0]   tlb_next_ff, tlb_next_in;
   logic [FREE_W-1:0]      free_ff, free_in;
   logic [PAGE_COUNT-1:0]  pt_valid_ff, pt_valid_in;

   // Finished item fields
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_hit_ff, res_hit_in;
   logic                   res_fault_ff, res_fault_in;
   logic                   res_oof_ff, res_oof_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;

   tlbpt_tlb_wr_type       tlb_wr;
   tlbpt_tlb_cmp_type      tlb_cmp;
   logic                   ram_wr_en;
   logic [FRAME_W-1:0]     ram_rd_data;
   logic                   out_free;
   logic [PA_W-1:0]        pa;

   tlbpt_tlb u_tlb (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (idx_ff),
      .page   (page_ff),
      .wr     (tlb_wr),
      .cmp    (tlb_cmp)
   );

   // Page table frame store; read address is the held page
   tlbpt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (PAGE_COUNT)
   ) u_pt_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (page_ff),
      .wr_data (free_ff[FRAME_W-1:0]),
      .rd_addr (page_ff),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pa         = PA_W'({res_frame_ff, offset_ff});

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      tlb_next_in  = tlb_next_ff;
      free_in      = free_ff;
      pt_valid_in  = pt_valid_ff;
      res_frame_in = res_frame_ff;
      res_hit_in   = res_hit_ff;
      res_fault_in = res_fault_ff;
      res_oof_in   = res_oof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      tlb_wr       = '0;
      ram_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in   = req_tdata[OFFSET_BITS +: PAGE_BITS];
               offset_in = req_tdata[OFFSET_BITS-1:0];
               idx_in    = '0;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tlb_cmp.match) begin
               res_frame_in = tlb_cmp.frame;
               res_hit_in   = 1'b1;
               res_fault_in = 1'b0;
               res_oof_in   = 1'b0;
               state_in     = ST_FINISH;
            end else if (idx_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
               state_in = ST_PTREAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_PTREAD: begin
            res_hit_in   = 1'b0;
            res_fault_in = 1'b0;
            res_oof_in   = 1'b0;
            state_in     = ST_FINISH;
            if (pt_valid_ff[page_ff]) begin
               res_frame_in = ram_rd_data;
               tlb_wr.en    = 1'b1;
            end else if (free_ff < FREE_W'(FRAME_COUNT)) begin
               // page fault: take the next free frame
               res_frame_in         = free_ff[FRAME_W-1:0];
               res_fault_in         = 1'b1;
               ram_wr_en            = 1'b1;
               pt_valid_in[page_ff] = 1'b1;
               free_in              = free_ff + 1'b1;
               tlb_wr.en            = 1'b1;
            end else begin
               res_frame_in = '0;
               res_oof_in   = 1'b1;
            end
            // FIFO refill of the TLB
            tlb_wr.idx   = tlb_next_ff;
            tlb_wr.page  = page_ff;
            tlb_wr.frame = res_frame_in;
            if (tlb_wr.en) begin
               tlb_next_in = (tlb_next_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                             '0 : tlb_next_ff + 1'b1;
            end
         end
         ST_FINISH, ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (res_oof_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = RSP_DATA_W'({FIDX_W'(res_frame_ff), pa});
               end
               rsp_user_in = {res_oof_ff, res_fault_ff, res_hit_ff};
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tlb_next_ff  <= '0;
         free_ff      <= '0;
         pt_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tlb_next_ff  <= tlb_next_in;
         free_ff      <= free_in;
         pt_valid_ff  <= pt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      page_ff      <= page_in;
      offset_ff    <= offset_in;
      res_frame_ff <= res_frame_in;
      res_hit_ff   <= res_hit_in;
      res_fault_ff <= res_fault_in;
      res_oof_ff   <= res_oof_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

endmodule

`default_nettype wire

>>> design/tlbpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/tlbpt_tlb.sv
// TLB entry storage with one shared compare unit reading one entry per cycle.
// Depends on tlbpt_pkg.
`default_nettype none

module tlbpt_tlb
   import tlbpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [TLB_IDX_W-1:0]  rd_idx,
   input  wire logic [PAGE_BITS-1:0]  page,
   input  wire tlbpt_tlb_wr_type      wr,
   output tlbpt_tlb_cmp_type          cmp
);

   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [PAGE_BITS-1:0]   page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_ff [TLB_ENTRIES];

   // Valid bits: cleared at reset, set on fill
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // Entry payload, gated by valid on read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         page_ff[wr.idx]  <= wr.page;
         frame_ff[wr.idx] <= wr.frame;
      end
   end

   // Shared compare on the selected entry
   always_comb begin
      cmp.match = valid_ff[rd_idx] && (page_ff[rd_idx] == page);
      cmp.frame = frame_ff[rd_idx];
   end

endmodule

`default_nettype wire
